[hdl/fthc_pkg.sv]
package fthc_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int NUM_WAYS    = 16;

  localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int KEY_W = 96;
  localparam int CNT_W = 32;
  localparam int IDX_W = 4;

  localparam logic [CNT_W-1:0] CNT_WRAP = 32'hFFFF_FFFE;
  localparam logic [CNT_W-1:0] CNT_ONE  = 32'h0000_0001;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_INSERT = 2'd1,
    OUT_FULL   = 2'd2
  } outcome_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [IDX_W-1:0] bucket_index;
  } fthc_in_t;

  typedef struct packed {
    outcome_t         outcome;
    logic [3:0]       way_index;
    logic [CNT_W-1:0] new_count;
  } fthc_out_t;

  typedef struct packed {
    logic load;    // capture the word and read its bucket row
    logic update;  // search the row, write it back unless full, present the result
  } fthc_cmd_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0][KEY_W-1:0] key;
    logic [NUM_WAYS-1:0][CNT_W-1:0] cnt;
  } row_t;

  // Bucket index modulo the bucket count, as a constant lookup.
  function automatic logic [BKT_W-1:0] bucket_of(logic [IDX_W-1:0] idx);
    logic [BKT_W-1:0] res;
    res = '0;
    for (int i = 0; i < (1 << IDX_W); i++) begin
      if (idx == IDX_W'(i)) begin
        res = BKT_W'(i % NUM_BUCKETS);
      end
    end
    return res;
  endfunction

  // Low four bits of a way number.
  function automatic logic [3:0] way_field(logic [WAY_W-1:0] w);
    logic [WAY_W+3:0] t;
    t = (WAY_W + 4)'(w);
    return t[3:0];
  endfunction

  // Saturating-wrap increment: never lands on zero.
  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c >= CNT_WRAP) begin
      r = CNT_ONE;
    end else begin
      r = c + CNT_ONE;
    end
    return r;
  endfunction

endpackage

[hdl/flow_table_hit_counter_core.sv]
// Flow table hit counter. Each word on req carries a flow key (source and
// destination address plus both ports) and a bucket index; the block looks the
// key up in a 16-bucket, 16-way table that reset leaves empty, and either
// increments the matching way's counter (wrapping to 1, never 0), inserts the
// key with count 1 into the first free way, or reports the bucket full. A word
// is taken at a rising edge with start high and busy low. Each word takes two
// steps: one reads the whole bucket row from the table memory, one compares
// all ways in parallel and writes the row back unless full; busy is high for
// the second. Exactly one result follows each word: rsp is valid for the single
// cycle in which done is high, right after busy falls, and it must be captured
// then because there is no back-pressure on the result side. The table needs
// no clearing pass after reset: per-bucket valid flags make untouched buckets
// read as empty, so the block takes words from the first cycle out of reset.
module flow_table_hit_counter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fthc_pkg::fthc_in_t  req,
  output logic                done,
  output fthc_pkg::fthc_out_t rsp
);
  import fthc_pkg::*;

  fthc_cmd_t cmd;

  // Sequence load and update.
  fthc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the table, search the bucket, drive the result.
  fthc_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

`ifndef SYNTH
  // Each accepted word occupies exactly one busy cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("busy did not end with a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result presented while busy");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.outcome == OUT_FULL) |-> (rsp.way_index == 4'd0 && rsp.new_count == '0))
    else $error("full bucket result carries nonzero fields");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.outcome != OUT_FULL) |-> (rsp.new_count != '0))
    else $error("updated counter is zero");
`endif

endmodule

[hdl/fthc_ctrl.sv]
module fthc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output fthc_pkg::fthc_cmd_t cmd
);
  import fthc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    cmd.load   = 1'b0;
    cmd.update = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_LOOK: begin
        busy       = 1'b1;
        cmd.update = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

[hdl/fthc_dpath.sv]
module fthc_dpath (
  input  logic                clk,
  input  logic                rst,
  input  fthc_pkg::fthc_cmd_t cmd,
  input  fthc_pkg::fthc_in_t  req,
  output logic                done,
  output fthc_pkg::fthc_out_t rsp
);
  import fthc_pkg::*;

  // Bucket rows: one wide read, one wide write back.
  row_t mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] row_valid;

  row_t             rd_row;
  logic             rd_valid;
  logic [KEY_W-1:0] key_r;
  logic [BKT_W-1:0] bkt_r;

  logic [NUM_WAYS-1:0][KEY_W-1:0] way_key;
  logic [NUM_WAYS-1:0][CNT_W-1:0] way_cnt;
  logic [NUM_WAYS-1:0]            eq;
  logic [NUM_WAYS-1:0]            empty;
  logic [NUM_WAYS-1:0]            pick;
  logic [WAY_W-1:0]               sel;
  logic                           found;
  logic                           sel_hit;
  logic [CNT_W-1:0]               cnt_new;
  row_t                           wr_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_row   <= mem[bucket_of(req.bucket_index)];
      rd_valid <= row_valid[bucket_of(req.bucket_index)];
      key_r    <= {req.src_addr, req.dst_addr, req.src_port, req.dst_port};
      bkt_r    <= bucket_of(req.bucket_index);
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_key[w] = rd_valid ? rd_row.key[w] : '0;
      way_cnt[w] = rd_valid ? rd_row.cnt[w] : '0;
      eq[w]      = (way_key[w] == key_r);
      empty[w]   = (way_key[w][KEY_W-1 -: 32] == 32'd0);
    end
    // Occupied exact match wins; otherwise first match or empty way.
    if (|(eq & ~empty)) begin
      pick = eq & ~empty;
    end else begin
      pick = eq | empty;
    end
    found = |pick;
    sel   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (pick[w]) begin
        sel = WAY_W'(w);
      end
    end
    sel_hit = eq[sel];
    cnt_new = sel_hit ? bump(way_cnt[sel]) : CNT_ONE;
    wr_row  = '{key: way_key, cnt: way_cnt};
    wr_row.key[sel] = key_r;
    wr_row.cnt[sel] = cnt_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.update && found) begin
      mem[bkt_r] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update && found) begin
        row_valid[bkt_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (!found) begin
        rsp.outcome   <= OUT_FULL;
        rsp.way_index <= '0;
        rsp.new_count <= '0;
      end else begin
        rsp.outcome   <= sel_hit ? OUT_HIT : OUT_INSERT;
        rsp.way_index <= way_field(sel);
        rsp.new_count <= cnt_new;
      end
    end
  end

endmodule
